// ----- sv/sync_object_table_assert.svh -----
// assertion macros shared by the sync object table modules
`ifndef SYNC_OBJECT_TABLE_ASSERT_SVH
`define SYNC_OBJECT_TABLE_ASSERT_SVH

// same-cycle implication under synchronous reset
`define SOT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication under synchronous reset
`define SOT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/sot_pkg.sv -----
package sot_pkg;

   // handle numbering
   localparam logic [31:0] HANDLE_BASE = 32'h7300_0000;

   // opcodes
   localparam logic [3:0] OP_NEW_EVENT   = 4'd0;
   localparam logic [3:0] OP_NEW_MUTEX   = 4'd1;
   localparam logic [3:0] OP_NEW_SEM     = 4'd2;
   localparam logic [3:0] OP_SET         = 4'd3;
   localparam logic [3:0] OP_RESET       = 4'd4;
   localparam logic [3:0] OP_REL_MUTEX   = 4'd5;
   localparam logic [3:0] OP_REL_SEM     = 4'd6;
   localparam logic [3:0] OP_WAIT        = 4'd7;
   localparam logic [3:0] OP_CLOSE       = 4'd8;
   localparam logic [3:0] OP_QUERY       = 4'd9;
   localparam logic [3:0] OP_THREAD_EXIT = 4'd10;
   localparam logic [3:0] OP_PROC_KILL   = 4'd11;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FAIL    = 3'd1;
   localparam logic [2:0] ST_SAT     = 3'd2;
   localparam logic [2:0] ST_ABAN    = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_WFAIL   = 3'd5;

   // object kinds
   localparam logic [1:0] KIND_EVENT = 2'd1;
   localparam logic [1:0] KIND_MUTEX = 2'd2;
   localparam logic [1:0] KIND_SEM   = 2'd3;

   // one table entry
   typedef struct packed {
      logic [1:0]         kind;
      logic               manual;
      logic               signaled;
      logic               abandoned;
      logic [31:0]        process;
      logic [31:0]        owner;
      logic [31:0]        recursion;
      logic signed [31:0] count;
      logic signed [31:0] maximum;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic idx_inc;
      logic exec;
      logic scan;
      logic alloc;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] op;
      logic       sem_bad;
      logic       idx_last;
      logic       cur_valid;
   } stat_type;

endpackage

// ----- sv/sot_datapath.sv -----
`include "sync_object_table_assert.svh"

module sot_datapath import sot_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [3:0]         req_opcode,
   input  logic [31:0]        req_handle_in,
   input  logic [31:0]        req_thread_id,
   input  logic [31:0]        req_process_id,
   input  logic               req_flag_a,
   input  logic               req_flag_b,
   input  logic signed [31:0] req_count_a,
   input  logic signed [31:0] req_count_b,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_handle_out,
   output logic signed [31:0] rsp_prior_count
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // captured command
   logic [3:0]         op_ff;
   logic [31:0]        tid_ff;
   logic [31:0]        proc_ff;
   logic               fa_ff;
   logic               fb_ff;
   logic signed [31:0] ca_ff;
   logic signed [31:0] cb_ff;
   logic               in_range_ff;
   logic [IDXW-1:0]    idx_ff;

   // table storage
   logic [SLOTS-1:0]   valid_ff;
   entry_type          mem [SLOTS];
   entry_type          rdata_ff;

   // staged result and output registers
   logic [2:0]         res_status_ff;
   logic [31:0]        res_hout_ff;
   logic signed [31:0] res_prev_ff;
   logic [2:0]         rsp_status_ff;
   logic [31:0]        rsp_hout_ff;
   logic signed [31:0] rsp_prev_ff;

   logic [31:0]        off;
   logic               at_handle;
   logic               cur_valid;
   logic               hit;
   logic [2:0]         def_status;
   logic signed [32:0] sem_sum;
   logic signed [32:0] sem_max;
   entry_type          wdata;
   logic               mem_we;
   logic               clr_valid;
   logic [2:0]         ex_status;
   logic signed [31:0] ex_prev;

   // handle to slot offset
   assign off       = req_handle_in - HANDLE_BASE;
   // creates and scans walk from slot zero, handle commands start at their slot
   assign at_handle = (off < 32'(SLOTS)) && (req_opcode >= OP_SET) &&
                      (req_opcode <= OP_QUERY);
   assign cur_valid = valid_ff[idx_ff];
   assign hit       = in_range_ff && cur_valid;
   assign sem_sum   = {rdata_ff.count[31], rdata_ff.count} + {ca_ff[31], ca_ff};
   assign sem_max   = {rdata_ff.maximum[31], rdata_ff.maximum};

   assign stat.op        = op_ff;
   assign stat.sem_bad   = (cb_ff <= 0) || (ca_ff < 0) || (ca_ff > cb_ff);
   assign stat.idx_last  = (idx_ff == IDXW'(SLOTS - 1));
   assign stat.cur_valid = cur_valid;

   // default status per opcode
   always_comb begin
      case (req_opcode)
         OP_WAIT:        def_status = ST_WFAIL;
         OP_THREAD_EXIT: def_status = ST_OK;
         OP_PROC_KILL:   def_status = ST_OK;
         default:        def_status = ST_FAIL;
      endcase
   end

   // entry update for single-slot commands, scans and creates
   always_comb begin
      wdata     = rdata_ff;
      mem_we    = 1'b0;
      clr_valid = 1'b0;
      ex_status = res_status_ff;
      ex_prev   = res_prev_ff;
      if (cmd.alloc) begin
         wdata           = '0;
         wdata.process   = proc_ff;
         mem_we          = 1'b1;
         case (op_ff)
            OP_NEW_EVENT: begin
               wdata.kind     = KIND_EVENT;
               wdata.manual   = fa_ff;
               wdata.signaled = fb_ff;
            end
            OP_NEW_MUTEX: begin
               wdata.kind = KIND_MUTEX;
               if (fa_ff) begin
                  wdata.owner     = tid_ff;
                  wdata.recursion = 32'd1;
               end
            end
            default: begin
               wdata.kind    = KIND_SEM;
               wdata.count   = ca_ff;
               wdata.maximum = cb_ff;
            end
         endcase
      end else if (cmd.scan) begin
         if (op_ff == OP_THREAD_EXIT) begin
            if (tid_ff != 32'd0 && cur_valid && rdata_ff.kind == KIND_MUTEX &&
                rdata_ff.owner == tid_ff) begin
               wdata.owner     = 32'd0;
               wdata.recursion = 32'd0;
               wdata.abandoned = 1'b1;
               mem_we          = 1'b1;
            end
         end else begin
            clr_valid = cur_valid && (rdata_ff.process == proc_ff);
         end
      end else if (cmd.exec && hit) begin
         case (op_ff)
            OP_SET, OP_RESET: begin
               if (rdata_ff.kind == KIND_EVENT) begin
                  wdata.signaled = (op_ff == OP_SET);
                  mem_we         = 1'b1;
                  ex_status      = ST_OK;
               end
            end
            OP_REL_MUTEX: begin
               if (rdata_ff.kind == KIND_MUTEX && rdata_ff.owner == tid_ff &&
                   rdata_ff.recursion != 32'd0) begin
                  wdata.recursion = rdata_ff.recursion - 32'd1;
                  if (rdata_ff.recursion == 32'd1) begin
                     wdata.owner = 32'd0;
                  end
                  mem_we    = 1'b1;
                  ex_status = ST_OK;
               end
            end
            OP_REL_SEM: begin
               if (rdata_ff.kind == KIND_SEM && ca_ff > 0 && sem_sum <= sem_max) begin
                  wdata.count = sem_sum[31:0];
                  mem_we      = 1'b1;
                  ex_prev     = rdata_ff.count;
                  ex_status   = ST_OK;
               end
            end
            OP_WAIT: begin
               if (rdata_ff.process == proc_ff) begin
                  case (rdata_ff.kind)
                     KIND_EVENT: begin
                        if (!rdata_ff.signaled) begin
                           ex_status = ST_TIMEOUT;
                        end else begin
                           ex_status = ST_SAT;
                           if (fa_ff && !rdata_ff.manual) begin
                              wdata.signaled = 1'b0;
                              mem_we         = 1'b1;
                           end
                        end
                     end
                     KIND_MUTEX: begin
                        if (rdata_ff.owner != 32'd0 && rdata_ff.owner != tid_ff) begin
                           ex_status = ST_TIMEOUT;
                        end else begin
                           ex_status = rdata_ff.abandoned ? ST_ABAN : ST_SAT;
                           if (fa_ff) begin
                              if (rdata_ff.owner == tid_ff) begin
                                 if (rdata_ff.recursion != '1) begin
                                    wdata.recursion = rdata_ff.recursion + 32'd1;
                                 end
                              end else begin
                                 wdata.owner     = tid_ff;
                                 wdata.recursion = 32'd1;
                              end
                              wdata.abandoned = 1'b0;
                              mem_we          = 1'b1;
                           end
                        end
                     end
                     KIND_SEM: begin
                        if (rdata_ff.count <= 0) begin
                           ex_status = ST_TIMEOUT;
                        end else begin
                           ex_status = ST_SAT;
                           if (fa_ff) begin
                              wdata.count = rdata_ff.count - 32'sd1;
                              mem_we      = 1'b1;
                           end
                        end
                     end
                     default: ex_status = ST_WFAIL;
                  endcase
               end
            end
            OP_CLOSE: begin
               clr_valid = 1'b1;
               ex_status = ST_OK;
            end
            OP_QUERY: ex_status = ST_OK;
            default:  ex_status = res_status_ff;
         endcase
      end
   end

   // command capture and slot index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_opcode;
         tid_ff      <= req_thread_id;
         proc_ff     <= req_process_id;
         fa_ff       <= req_flag_a;
         fb_ff       <= req_flag_b;
         ca_ff       <= req_count_a;
         cb_ff       <= req_count_b;
         in_range_ff <= (off < 32'(SLOTS));
         idx_ff      <= at_handle ? off[IDXW-1:0] : '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.alloc) begin
         valid_ff[idx_ff] <= 1'b1;
      end else if (clr_valid) begin
         valid_ff[idx_ff] <= 1'b0;
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= wdata;
      end
      rdata_ff <= mem[idx_ff];
   end

   // staged result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= def_status;
         res_hout_ff   <= 32'd0;
         res_prev_ff   <= 32'sd0;
      end else if (cmd.alloc) begin
         res_status_ff <= ST_OK;
         res_hout_ff   <= HANDLE_BASE + 32'(idx_ff);
      end else if (cmd.exec) begin
         res_status_ff <= ex_status;
         res_prev_ff   <= ex_prev;
      end
   end

   // output registers
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_hout_ff   <= res_hout_ff;
         rsp_prev_ff   <= res_prev_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_hout_ff;
   assign rsp_prior_count = rsp_prev_ff;

   // a create only takes a free slot
   `SOT_ASSERT_NOW(a_alloc_free, clock, reset, cmd.alloc, !cur_valid)
   // a create leaves the slot in use with its handle returned
   `SOT_ASSERT_NEXT(a_alloc_handle, clock, reset, cmd.alloc,
      valid_ff[$past(idx_ff)] && res_hout_ff == HANDLE_BASE + 32'($past(idx_ff)))
   // an out-of-range handle never succeeds
   `SOT_ASSERT_NEXT(a_bad_handle, clock, reset, cmd.exec && !in_range_ff,
      res_status_ff == ST_FAIL || res_status_ff == ST_WFAIL)

endmodule

// ----- sv/sot_ctrl.sv -----
`include "sync_object_table_assert.svh"

module sot_ctrl import sot_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_RD, S_EXEC, S_FIND, S_SRD, S_SCHK, S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // command decode from state
   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == S_IDLE) && req_valid;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.scan    = (state_ff == S_SCHK);
      cmd.alloc   = (state_ff == S_FIND) && !stat.cur_valid;
      cmd.idx_inc = ((state_ff == S_FIND) && stat.cur_valid && !stat.idx_last) ||
                    ((state_ff == S_SCHK) && !stat.idx_last);
      cmd.publish = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // sequencer and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               case (stat.op)
                  OP_NEW_EVENT, OP_NEW_MUTEX: state_ff <= S_FIND;
                  OP_NEW_SEM:    state_ff <= stat.sem_bad ? S_DONE : S_FIND;
                  OP_SET, OP_RESET, OP_REL_MUTEX, OP_REL_SEM,
                  OP_WAIT, OP_CLOSE, OP_QUERY: state_ff <= S_RD;
                  OP_THREAD_EXIT, OP_PROC_KILL: state_ff <= S_SRD;
                  default:       state_ff <= S_DONE;
               endcase
            end
            S_RD:   state_ff <= S_EXEC;
            S_EXEC: state_ff <= S_DONE;
            S_FIND: begin
               if (!stat.cur_valid || stat.idx_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_SRD:  state_ff <= S_SCHK;
            S_SCHK: state_ff <= stat.idx_last ? S_DONE : S_SRD;
            S_DONE: begin
               if (cmd.publish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // the block is busy right after taking a transaction
   `SOT_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a published result raises response valid and returns the sequencer to idle
   `SOT_ASSERT_NEXT(a_publish, clock, reset, cmd.publish, rsp_valid && state_ff == S_IDLE)
   // a scan step never runs outside a thread exit or process destroy
   `SOT_ASSERT_NOW(a_scan_op, clock, reset, cmd.scan,
      stat.op == OP_THREAD_EXIT || stat.op == OP_PROC_KILL)

endmodule

// ----- sv/sync_object_table.sv -----
// Sync object table: a table of SLOTS events, mutexes and semaphores, one command in and
// one result out per transaction over valid/ready channels. Handles are 0x73000000 + slot.
// Commands go one at a time through a controller and a single-port entry memory with a
// registered read; a finished result sits in an output register, so the next command is
// taken while it waits. Handle commands read their slot and then execute, creates walk
// from slot zero to the lowest free slot, and thread exit and process destroy walk every
// slot with a read step and a check step each. Once the result is registered the
// sequencer is idle and can accept the next command; a result is registered only after
// the previous one has been taken. Slot occupancy is held in flip-flops cleared by reset,
// so the table is usable right after reset with no clearing pass.
module sync_object_table import sot_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_opcode,
   input  logic [31:0]        req_handle_in,
   input  logic [31:0]        req_thread_id,
   input  logic [31:0]        req_process_id,
   input  logic               req_flag_a,
   input  logic               req_flag_b,
   input  logic signed [31:0] req_count_a,
   input  logic signed [31:0] req_count_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_handle_out,
   output logic signed [31:0] rsp_prior_count
);

   cmd_type  cmd;
   stat_type stat;

   // command sequencer
   sot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage and entry update
   sot_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_handle_in   (req_handle_in),
      .req_thread_id   (req_thread_id),
      .req_process_id  (req_process_id),
      .req_flag_a      (req_flag_a),
      .req_flag_b      (req_flag_b),
      .req_count_a     (req_count_a),
      .req_count_b     (req_count_b),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_prior_count (rsp_prior_count)
   );

endmodule
